// ===== hdl/prime_sieve_counter_core_assert.svh =====
// Assertion macros used by the prime sieve counter controller.
`ifndef PRIME_SIEVE_COUNTER_CORE_ASSERT_SVH
`define PRIME_SIEVE_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define PSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/psc_pkg.sv =====
// Shared constants and controller/datapath handshake types for the prime sieve counter.
package psc_pkg;

    // Field widths of the request and response words.
    localparam int LIM_W = 16;
    localparam int CNT_W = 16;

    // Width of the internal number walkers (limit plus one stride fits).
    localparam int NUM_W = LIM_W + 1;

    // Default largest accepted limit.
    localparam int DEF_MAX_LIMIT = 65535;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the limit, reset walkers
        logic clr_step;   // clear one flag, advance index
        logic cand_init;  // start candidates at three
        logic cand_read;  // read the flag of the candidate
        logic cand_next;  // move to the next odd candidate
        logic mark_init;  // start multiples at candidate squared
        logic mark_step;  // mark one multiple, advance by candidate
        logic cnt_init;   // start counting at three with one prime
        logic cnt_read;   // read one odd flag for counting
        logic res_load;   // move the count into the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lim_small;  // incoming limit is below two
        logic clr_last;   // index has reached the limit
        logic sq_gt_lim;  // candidate squared exceeds the limit
        logic flag;       // registered flag read data
        logic m_gt_lim;   // multiple exceeds the limit
        logic idx_gt_lim; // count index exceeds the limit
    } sts_t;

endpackage

// ===== hdl/psc_limit_if.sv =====
// Request channel carrying one limit word.
interface psc_limit_if;
    import psc_pkg::*;

    logic             valid;
    logic             ready;
    logic [LIM_W-1:0] limit;

    modport source (output valid, output limit, input ready);
    modport sink (input valid, input limit, output ready);
endinterface

// ===== hdl/psc_count_if.sv =====
// Response channel carrying one prime count word.
interface psc_count_if;
    import psc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink (input valid, input prime_count, output ready);
endinterface

// ===== hdl/prime_sieve_counter_core.sv =====
// Top level of the prime sieve counter: controller, datapath and channel ports.
//
//  Channel | Dir | Payload            | Meaning
//  req     | in  | limit[15:0]        | inclusive upper bound to sieve
//  rsp     | out | prime_count[15:0]  | number of primes at most the limit
//
// Each word clears the flag store up to limit L, marks the multiples of every odd candidate
// whose square is at most L and that is still unmarked, then counts the unmarked odd
// entries. The flag store has a single port, at one access per cycle.
// A limit below two goes straight to the result phase, without touching the store.
// Reset is asynchronous and clears control state; the store is cleared per word.
// The next word is accepted while a result waits on rsp; a stalled result holds.
module prime_sieve_counter_core #(
    parameter int MAX_LIMIT = psc_pkg::DEF_MAX_LIMIT
) (
    input  logic        clk,
    input  logic        rst_n,
    psc_limit_if.sink   req,
    psc_count_if.source rsp
);
    import psc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    psc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    psc_dp #(
        .MAX_LIMIT (MAX_LIMIT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit       (req.limit),
        .prime_count (rsp.prime_count),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ===== hdl/psc_ram.sv =====
// Generic single-port RAM with registered read data.
module psc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle: write or registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== hdl/psc_ctrl.sv =====
// Sequencer that steps the sieve through clear, mark, count and result phases.
`include "prime_sieve_counter_core_assert.svh"

module psc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output psc_pkg::cmd_t cmd,
    input  psc_pkg::sts_t sts
);
    import psc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CAND,
        ST_CAND_WAIT,
        ST_MARK,
        ST_COUNT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Next state, commands and response valid.
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.lim_small ? ST_FINISH : ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.cand_init = 1'b1;
                    state_next    = ST_CAND;
                end
            end
            ST_CAND:
            begin
                if (sts.sq_gt_lim)
                begin
                    cmd.cnt_init = 1'b1;
                    state_next   = ST_COUNT;
                end
                else
                begin
                    cmd.cand_read = 1'b1;
                    state_next    = ST_CAND_WAIT;
                end
            end
            ST_CAND_WAIT:
            begin
                if (sts.flag)
                begin
                    cmd.cand_next = 1'b1;
                    state_next    = ST_CAND;
                end
                else
                begin
                    cmd.mark_init = 1'b1;
                    state_next    = ST_MARK;
                end
            end
            ST_MARK:
            begin
                if (sts.m_gt_lim)
                begin
                    cmd.cand_next = 1'b1;
                    state_next    = ST_CAND;
                end
                else
                begin
                    cmd.mark_step = 1'b1;
                end
            end
            ST_COUNT:
            begin
                if (sts.idx_gt_lim)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.cnt_read = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.res_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and response valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // At most one flag store access is requested per cycle.
    `PSC_ASSERT_NOW(a_one_access, 1'b1,
        $onehot0({cmd.clr_step, cmd.cand_read, cmd.mark_step, cmd.cnt_read}),
        "psc_ctrl: more than one flag store access in a cycle")

    // Marks are never written beyond the limit.
    `PSC_ASSERT_NOW(a_mark_in_range, cmd.mark_step, !sts.m_gt_lim,
        "psc_ctrl: mark written beyond the limit")

    // A finished count waits while the previous result is still held.
    `PSC_ASSERT_NEXT(a_result_waits,
        state_reg == ST_FINISH && rsp_valid_reg && !rsp_ready,
        state_reg == ST_FINISH && rsp_valid_reg,
        "psc_ctrl: pending result overwritten")

endmodule

// ===== hdl/psc_dp.sv =====
// Datapath with the flag store, number walkers, prime counter and result register.
module psc_dp #(
    parameter int MAX_LIMIT = psc_pkg::DEF_MAX_LIMIT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [psc_pkg::LIM_W-1:0] limit,
    output logic [psc_pkg::CNT_W-1:0] prime_count,
    input  psc_pkg::cmd_t             cmd,
    output psc_pkg::sts_t             sts
);
    import psc_pkg::*;

    localparam int          DEPTH  = MAX_LIMIT + 1;
    localparam int          ADDR_W = $clog2(DEPTH);
    localparam logic [31:0] MAX_L  = 32'(MAX_LIMIT);

    logic [LIM_W-1:0]  lim_reg;
    logic [LIM_W-1:0]  lim_sat;
    logic [NUM_W-1:0]  lim_ext;
    logic [NUM_W-1:0]  idx_reg;
    logic [NUM_W-1:0]  p_reg;
    logic [NUM_W-1:0]  sq_reg;
    logic [NUM_W-1:0]  m_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  result_reg;
    logic              rd_pend_reg;
    logic [NUM_W-1:0]  addr_num;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic              ram_rdata;

    // Limits above MAX_LIMIT saturate to it, so they fit the store depth.
    assign lim_sat = (32'(limit) > MAX_L) ? MAX_L[LIM_W-1:0] : limit;
    assign lim_ext = NUM_W'(lim_reg);

    // Status toward the controller.
    assign sts.lim_small  = (limit < LIM_W'(2));
    assign sts.clr_last   = (idx_reg == lim_ext);
    assign sts.sq_gt_lim  = (sq_reg > lim_ext);
    assign sts.flag       = ram_rdata;
    assign sts.m_gt_lim   = (m_reg > lim_ext);
    assign sts.idx_gt_lim = (idx_reg > lim_ext);

    // Flag store address select; every address used is at most the limit.
    always_comb
    begin
        if (cmd.cand_read)
        begin
            addr_num = p_reg;
        end
        else if (cmd.mark_step)
        begin
            addr_num = m_reg;
        end
        else
        begin
            addr_num = idx_reg;
        end
    end

    assign ram_addr = ADDR_W'(addr_num);
    assign ram_we   = cmd.clr_step || cmd.mark_step;

    psc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_flags (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd.mark_step),
        .rdata (ram_rdata)
    );

    // Walkers, counter and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lim_reg   <= lim_sat;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        if (cmd.clr_step)
        begin
            idx_reg <= idx_reg + NUM_W'(1);
        end
        if (cmd.cand_init)
        begin
            p_reg  <= NUM_W'(3);
            sq_reg <= NUM_W'(9);
        end
        // Next odd square: (p+2)^2 = p^2 + 4p + 4.
        if (cmd.cand_next)
        begin
            p_reg  <= p_reg + NUM_W'(2);
            sq_reg <= sq_reg + (p_reg << 2) + NUM_W'(4);
        end
        if (cmd.mark_init)
        begin
            m_reg <= sq_reg;
        end
        if (cmd.mark_step)
        begin
            m_reg <= m_reg + p_reg;
        end
        if (cmd.cnt_init)
        begin
            idx_reg   <= NUM_W'(3);
            count_reg <= CNT_W'(1);
        end
        if (cmd.cnt_read)
        begin
            idx_reg <= idx_reg + NUM_W'(2);
        end
        // Count an odd entry in the cycle after its read, when it is unmarked.
        if (rd_pend_reg && !ram_rdata)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        if (cmd.res_load)
        begin
            result_reg <= count_reg;
        end
    end

    // Marks which cycle carries counting read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.cnt_read;
        end
    end

    assign prime_count = result_reg;

endmodule
